@@ sv/rsi_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths and side-band type for the ray/sphere intersection pipeline.
// No dependencies; used by rsi_sqrt and ray_sphere_intersect_unit.
package rsi_pkg;

    localparam int COORD_W  = 24;   // Q12.12 coordinates, limits and t
    localparam int DIR_W    = 16;   // Q1.14 direction
    localparam int RAD_W    = 23;   // unsigned Q11.12 radius
    localparam int Q_FRAC   = 12;
    localparam int DIR_FRAC = 14;

    localparam int M_W      = COORD_W + 1;          // origin - center
    localparam int MD_W     = M_W + DIR_W;          // m * dir
    localparam int MM_W     = 2 * M_W;              // m * m
    localparam int RR_W     = 2 * RAD_W;            // r * r
    localparam int B26_W    = MD_W + 2;             // sum of three m * dir
    localparam int C24_W    = MM_W + 1;             // m.m - r*r
    localparam int B_W      = B26_W - DIR_FRAC;     // b in Q12.12
    localparam int C_W      = C24_W - Q_FRAC;       // c in Q12.12
    localparam int BB_W     = 2 * B_W;              // b * b
    localparam int DISC_W   = BB_W - Q_FRAC + 1;    // trunc(b*b) - c
    localparam int DISC_USE = 44;                   // discriminant stays below 2^43
    localparam int SQ_IN_W  = DISC_USE + Q_FRAC;    // radicand disc << 12
    localparam int SQ_OUT_W = SQ_IN_W / 2;          // one root bit per stage
    localparam int SQ_REM_W = SQ_OUT_W + 3;
    localparam int T_W      = SQ_OUT_W + 3;         // root - b, signed

    localparam logic signed [T_W-1:0] T_SAT_MAX = T_W'(8388607);
    localparam logic signed [T_W-1:0] T_SAT_MIN = -T_W'(8388608);

    // travels beside the radicand through the root stages
    typedef struct packed {
        logic               rej;
        logic [B_W-1:0]     b;
        logic [COORD_W-1:0] tmin;
        logic [COORD_W-1:0] tmax;
    } t_side;

endpackage

@@ sv/rsi_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined floor integer square root, one root bit per register stage.
// Depends on rsi_pkg for widths and the side-band word type.
module rsi_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [rsi_pkg::SQ_IN_W-1:0]   i_rad,
    input  rsi_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [rsi_pkg::SQ_OUT_W-1:0]  o_root,
    output rsi_pkg::t_side                o_side
);
    import rsi_pkg::*;

    localparam int N = SQ_OUT_W;

    logic [N-1:0]          r_vld;
    logic [SQ_REM_W-1:0]   r_rem  [N];
    logic [SQ_OUT_W-1:0]   r_root [N];
    logic [SQ_IN_W-1:0]    r_rad  [N];
    t_side                 r_side [N];

    logic [SQ_REM_W-1:0]   n_rem  [N];
    logic [SQ_OUT_W-1:0]   n_root [N];
    logic [SQ_IN_W-1:0]    n_rad  [N];

    always_comb begin
        logic [SQ_REM_W-1:0] rem_in, cur, trial;
        logic [SQ_OUT_W-1:0] root_in;
        logic [SQ_IN_W-1:0]  rad_in;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = i_rad;
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                rad_in  = r_rad[k-1];
            end
            // bring down the next two radicand bits, try root*4 + 1
            cur   = {rem_in[SQ_REM_W-3:0], rad_in[SQ_IN_W-1 -: 2]};
            trial = SQ_REM_W'({root_in, 2'b01});
            if (cur >= trial) begin
                n_rem[k]  = cur - trial;
                n_root[k] = {root_in[SQ_OUT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur;
                n_root[k] = {root_in[SQ_OUT_W-2:0], 1'b0};
            end
            n_rad[k] = {rad_in[SQ_IN_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
        for (int k = 0; k < N; k++) begin
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_rad[k]  <= n_rad[k];
            r_side[k] <= (k == 0) ? i_side : r_side[k-1];
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

@@ sv/ray_sphere_intersect_unit.sv @@
`timescale 1ns / 1ps
// Ray / sphere far-root intersection test, fully pipelined.
// Depends on rsi_pkg and rsi_sqrt.
//
// Usage:
//   Drive a ray (origin, direction, t limits) and a sphere (center, radius)
//   on the i_ ports and raise start. The word is taken at any rising edge
//   with start high and busy low; busy is always low, so one word may enter
//   every cycle.
//   Each word gives exactly one result, in order: o_valid is high for one
//   cycle with o_hit, o_root_valid and o_t_value. The receiver has no way to
//   hold results off and none is needed.
//   Stages: 5 arithmetic stages, 28 square-root stages and 2 finishing
//   stages lie between start and o_valid.
//   Throughput: one word per cycle, set by the square root being unrolled
//   into one root bit per register stage.
//   Early-rejected rays return hit = 0, root_valid = 0, t_value = 0.
//   Synchronous active-low reset clears all valid bits; words in flight are
//   dropped and no strobe follows.
module ray_sphere_intersect_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rsi_pkg::COORD_W-1:0]   i_origin_x,
    input  logic [rsi_pkg::COORD_W-1:0]   i_origin_y,
    input  logic [rsi_pkg::COORD_W-1:0]   i_origin_z,
    input  logic [rsi_pkg::DIR_W-1:0]     i_dir_x,
    input  logic [rsi_pkg::DIR_W-1:0]     i_dir_y,
    input  logic [rsi_pkg::DIR_W-1:0]     i_dir_z,
    input  logic [rsi_pkg::COORD_W-1:0]   i_center_x,
    input  logic [rsi_pkg::COORD_W-1:0]   i_center_y,
    input  logic [rsi_pkg::COORD_W-1:0]   i_center_z,
    input  logic [rsi_pkg::RAD_W-1:0]     i_sphere_radius,
    input  logic [rsi_pkg::COORD_W-1:0]   i_t_near_limit,
    input  logic [rsi_pkg::COORD_W-1:0]   i_t_far_limit,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_root_valid,
    output logic [rsi_pkg::COORD_W-1:0]   o_t_value
);
    import rsi_pkg::*;

    assign busy = 1'b0;

    // stage 1: m = origin - center
    logic                       r1_vld;
    logic signed [M_W-1:0]      r1_m [3];
    logic signed [DIR_W-1:0]    r1_d [3];
    logic [RAD_W-1:0]           r1_r;
    logic [COORD_W-1:0]         r1_tmin, r1_tmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
        r1_m[0] <= $signed({i_origin_x[COORD_W-1], i_origin_x})
                 - $signed({i_center_x[COORD_W-1], i_center_x});
        r1_m[1] <= $signed({i_origin_y[COORD_W-1], i_origin_y})
                 - $signed({i_center_y[COORD_W-1], i_center_y});
        r1_m[2] <= $signed({i_origin_z[COORD_W-1], i_origin_z})
                 - $signed({i_center_z[COORD_W-1], i_center_z});
        r1_d[0] <= $signed(i_dir_x);
        r1_d[1] <= $signed(i_dir_y);
        r1_d[2] <= $signed(i_dir_z);
        r1_r    <= i_sphere_radius;
        r1_tmin <= i_t_near_limit;
        r1_tmax <= i_t_far_limit;
    end

    // stage 2: products
    logic                       r2_vld;
    logic signed [MD_W-1:0]     r2_md [3];
    logic signed [MM_W-1:0]     r2_mm [3];
    logic [RR_W-1:0]            r2_rr;
    logic [COORD_W-1:0]         r2_tmin, r2_tmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        for (int i = 0; i < 3; i++) begin
            r2_md[i] <= MD_W'(r1_m[i] * MD_W'(r1_d[i]));
            r2_mm[i] <= r1_m[i] * r1_m[i];
        end
        r2_rr   <= r1_r * r1_r;
        r2_tmin <= r1_tmin;
        r2_tmax <= r1_tmax;
    end

    // stage 3: dot sums, floor to Q12.12
    logic signed [B26_W-1:0]    s3_b26;
    logic signed [C24_W-1:0]    s3_c24;
    logic                       r3_vld;
    logic signed [B_W-1:0]      r3_b;
    logic signed [C_W-1:0]      r3_c;
    logic [COORD_W-1:0]         r3_tmin, r3_tmax;

    assign s3_b26 = B26_W'(r2_md[0]) + B26_W'(r2_md[1]) + B26_W'(r2_md[2]);
    assign s3_c24 = C24_W'(r2_mm[0]) + C24_W'(r2_mm[1]) + C24_W'(r2_mm[2])
                  - $signed(C24_W'(r2_rr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_b    <= s3_b26[B26_W-1:DIR_FRAC];
        r3_c    <= s3_c24[C24_W-1:Q_FRAC];
        r3_tmin <= r2_tmin;
        r3_tmax <= r2_tmax;
    end

    // stage 4: b*b and the outside-and-pointing-away test
    logic                       r4_vld;
    logic signed [BB_W-1:0]     r4_bb;
    logic signed [B_W-1:0]      r4_b;
    logic signed [C_W-1:0]      r4_c;
    logic                       r4_away;
    logic [COORD_W-1:0]         r4_tmin, r4_tmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_bb   <= r3_b * r3_b;
        r4_b    <= r3_b;
        r4_c    <= r3_c;
        r4_away <= (r3_c > 0) && (r3_b > 0);
        r4_tmin <= r3_tmin;
        r4_tmax <= r3_tmax;
    end

    // stage 5: discriminant, radicand for the root pipe
    logic signed [DISC_W-1:0]   s5_disc;
    logic                       s5_rej;
    logic                       r5_vld;
    logic [SQ_IN_W-1:0]         r5_rad;
    t_side                      r5_side;

    assign s5_disc = $signed(DISC_W'(r4_bb[BB_W-1:Q_FRAC])) - DISC_W'(r4_c);
    assign s5_rej  = r4_away || s5_disc[DISC_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_rad       <= s5_rej ? '0 : {s5_disc[DISC_USE-1:0], {Q_FRAC{1'b0}}};
        r5_side.rej  <= s5_rej;
        r5_side.b    <= r4_b;
        r5_side.tmin <= r4_tmin;
        r5_side.tmax <= r4_tmax;
    end

    logic                       sq_vld;
    logic [SQ_OUT_W-1:0]        sq_root;
    t_side                      sq_side;

    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_vld),
        .i_rad   (r5_rad),
        .i_side  (r5_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage 6: t = sqrt - b
    logic                       r6_vld;
    logic signed [T_W-1:0]      r6_t;
    t_side                      r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= sq_vld;
        end
        r6_t    <= $signed(T_W'(sq_root)) - T_W'($signed(sq_side.b));
        r6_side <= sq_side;
    end

    // stage 7: limit test on the wide t, saturate for display
    logic signed [T_W-1:0]      s7_tmin, s7_tmax;
    logic [COORD_W-1:0]         s7_sat;
    logic                       s7_in;

    assign s7_tmin = T_W'($signed(r6_side.tmin));
    assign s7_tmax = T_W'($signed(r6_side.tmax));
    assign s7_in   = (s7_tmin <= r6_t) && (r6_t <= s7_tmax);

    always_comb begin
        if (r6_t > T_SAT_MAX) begin
            s7_sat = T_SAT_MAX[COORD_W-1:0];
        end else if (r6_t < T_SAT_MIN) begin
            s7_sat = T_SAT_MIN[COORD_W-1:0];
        end else begin
            s7_sat = r6_t[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r6_vld;
        end
        o_hit        <= !r6_side.rej && s7_in;
        o_root_valid <= !r6_side.rej;
        o_t_value    <= r6_side.rej ? '0 : s7_sat;
    end

endmodule

@@ dv/ray_sphere_intersect_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ray_sphere_intersect_unit: directed probes, then random rays,
// each result compared against an in-bench fixed-point far-root predictor.
// Depends on rsi_pkg and the ray_sphere_intersect_unit RTL.
module ray_sphere_intersect_unit_test;

    import rsi_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [RAD_W-1:0]          radius;
        logic signed [COORD_W-1:0] t_near;
        logic signed [COORD_W-1:0] t_far;
    } ray_query_t;

    typedef struct packed {
        logic               hit;
        logic               root_valid;
        logic [COORD_W-1:0] t_value;
    } ray_result_t;

    // typed = 1: the expected word is written in the row, else the predictor supplies it
    typedef struct packed {
        ray_query_t  query;
        logic        typed;
        ray_result_t want;
    } probe_t;

    localparam longint T_HI = 8388607;
    localparam longint T_LO = -8388608;

    localparam logic signed [COORD_W-1:0] P0   = '0;
    localparam logic signed [COORD_W-1:0] P1   = 24'sd4096;
    localparam logic signed [COORD_W-1:0] PH   = 24'sd2048;
    localparam logic signed [COORD_W-1:0] P10  = 24'sd40960;
    localparam logic signed [COORD_W-1:0] N10  = -24'sd40960;
    localparam logic signed [COORD_W-1:0] P20  = 24'sd81920;
    localparam logic signed [COORD_W-1:0] TA   = 24'sd45056;
    localparam logic signed [COORD_W-1:0] TB   = 24'sd45055;
    localparam logic signed [COORD_W-1:0] TC   = 24'sd45057;
    localparam logic signed [COORD_W-1:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] CMIN = 24'sh800000;
    localparam logic signed [COORD_W-1:0] C5   = 24'sh555555;
    localparam logic signed [COORD_W-1:0] CA   = 24'shAAAAAA;
    localparam logic signed [DIR_W-1:0]   D0   = '0;
    localparam logic signed [DIR_W-1:0]   D1   = 16'sd16384;
    localparam logic signed [DIR_W-1:0]   DMAX = 16'sh7FFF;
    localparam logic signed [DIR_W-1:0]   DMIN = 16'sh8000;
    localparam logic signed [DIR_W-1:0]   D5   = 16'sh5555;
    localparam logic signed [DIR_W-1:0]   DA   = 16'shAAAA;
    localparam logic [RAD_W-1:0]          R0   = '0;
    localparam logic [RAD_W-1:0]          R1   = 23'd4096;
    localparam logic [RAD_W-1:0]          R2   = 23'd8192;
    localparam logic [RAD_W-1:0]          RLSB = 23'd1;
    localparam logic [RAD_W-1:0]          RMAX = 23'h7FFFFF;
    localparam logic [RAD_W-1:0]          R2A  = 23'h2AAAAA;
    localparam logic [RAD_W-1:0]          R55  = 23'h555555;

    localparam ray_result_t NO_ROOT = '0;
    localparam ray_result_t UNTYPED = '0;

    localparam int N_PROBES = 22;
    localparam int N_RANDOM = 1800;

    localparam probe_t PROBES [N_PROBES] = '{
        // degenerate: everything zero, root at t = 0
        '{'{P0, P0, P0, D0, D0, D0, P0, P0, P0, R0, P0, P0}, 1'b1, '{1'b1, 1'b1, P0}},
        // outside and pointing away
        '{'{P10, P0, P0, D1, D0, D0, P0, P0, P0, R1, P0, P20}, 1'b1, NO_ROOT},
        // outside, passes beside the sphere
        '{'{P0, P10, P0, D1, D0, D0, P0, P0, P0, R1, P0, P20}, 1'b1, NO_ROOT},
        // head-on from -10: far root at 11.0, then limits on and around it
        '{'{N10, P0, P0, D1, D0, D0, P0, P0, P0, R1, P0, P20}, 1'b1, '{1'b1, 1'b1, TA}},
        '{'{N10, P0, P0, D1, D0, D0, P0, P0, P0, R1, P0, TA}, 1'b1, '{1'b1, 1'b1, TA}},
        '{'{N10, P0, P0, D1, D0, D0, P0, P0, P0, R1, P0, TB}, 1'b1, '{1'b0, 1'b1, TA}},
        '{'{N10, P0, P0, D1, D0, D0, P0, P0, P0, R1, TA, P20}, 1'b1, '{1'b1, 1'b1, TA}},
        '{'{N10, P0, P0, D1, D0, D0, P0, P0, P0, R1, TC, P20}, 1'b1, '{1'b0, 1'b1, TA}},
        '{'{N10, P0, P0, D1, D0, D0, P0, P0, P0, R1, P20, P0}, 1'b1, '{1'b0, 1'b1, TA}},
        '{'{N10, P0, P0, D1, D0, D0, P0, P0, P0, R1, CMIN, CMAX}, 1'b1, '{1'b1, 1'b1, TA}},
        // origin at the center, half way out, and on the surface pointing out
        '{'{P0, P0, P0, D1, D0, D0, P0, P0, P0, R1, P0, CMAX}, 1'b1, '{1'b1, 1'b1, P1}},
        '{'{PH, P0, P0, D1, D0, D0, P0, P0, P0, R1, P0, CMAX}, 1'b1, '{1'b1, 1'b1, PH}},
        '{'{P1, P0, P0, D1, D0, D0, P0, P0, P0, R1, P0, CMAX}, 1'b1, '{1'b1, 1'b1, P0}},
        // zero direction from outside
        '{'{P10, P0, P0, D0, D0, D0, P0, P0, P0, R1, P0, P20}, 1'b0, UNTYPED},
        // field extremes: far root saturates high in the first two, the third points away
        '{'{CMAX, CMAX, CMAX, DMIN, DMIN, DMIN, CMIN, CMIN, CMIN, RMAX, CMIN, CMAX},
          1'b0, UNTYPED},
        '{'{CMIN, CMIN, CMIN, DMAX, DMAX, DMAX, CMAX, CMAX, CMAX, R0, CMIN, CMAX},
          1'b0, UNTYPED},
        '{'{CMAX, CMAX, CMAX, DMAX, DMAX, DMAX, CMIN, CMIN, CMIN, RMAX, CMIN, CMAX},
          1'b1, NO_ROOT},
        '{'{CMAX, CMAX, CMAX, DMIN, DMAX, DMIN, CMAX, CMAX, CMAX, RMAX, CMIN, CMAX},
          1'b0, UNTYPED},
        // non-unit direction, and a one-lsb sphere
        '{'{N10, N10, N10, DMAX, DMAX, DMAX, P0, P0, P0, R2, P0, CMAX}, 1'b0, UNTYPED},
        '{'{N10, P0, P0, D1, D0, D0, P0, P0, P0, RLSB, P0, P20}, 1'b0, UNTYPED},
        // alternating bit patterns
        '{'{C5, CA, C5, DA, D5, DA, CA, C5, CA, R2A, CA, C5}, 1'b0, UNTYPED},
        '{'{CA, C5, CA, D5, DA, D5, C5, CA, C5, R55, C5, CA}, 1'b0, UNTYPED}
    };

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    ray_query_t  ray_in  = '0;
    logic        busy;
    logic        o_valid;
    logic        o_hit;
    logic        o_root_valid;
    logic [COORD_W-1:0] o_t_value;

    ray_result_t pending_hits [$];
    int          miscompares = 0;

    ray_sphere_intersect_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_origin_x      (ray_in.origin_x),
        .i_origin_y      (ray_in.origin_y),
        .i_origin_z      (ray_in.origin_z),
        .i_dir_x         (ray_in.dir_x),
        .i_dir_y         (ray_in.dir_y),
        .i_dir_z         (ray_in.dir_z),
        .i_center_x      (ray_in.center_x),
        .i_center_y      (ray_in.center_y),
        .i_center_z      (ray_in.center_z),
        .i_sphere_radius (ray_in.radius),
        .i_t_near_limit  (ray_in.t_near),
        .i_t_far_limit   (ray_in.t_far),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_root_valid    (o_root_valid),
        .o_t_value       (o_t_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // floor(sqrt(v)); v stays below 2^57, so the root fits in 29 bits
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = 29; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic ray_result_t far_root_hit(ray_query_t q);
        longint mx, my, mz, dot26, mm24, rad, b, c, bb, disc, t, t_min, t_max;
        ray_result_t res;
        mx    = longint'(q.origin_x) - longint'(q.center_x);
        my    = longint'(q.origin_y) - longint'(q.center_y);
        mz    = longint'(q.origin_z) - longint'(q.center_z);
        dot26 = mx * longint'(q.dir_x) + my * longint'(q.dir_y) + mz * longint'(q.dir_z);
        rad   = longint'({1'b0, q.radius});
        mm24  = mx * mx + my * my + mz * mz - rad * rad;
        b     = dot26 >>> DIR_FRAC;     // arithmetic shift = floor
        c     = mm24 >>> Q_FRAC;
        t_min = longint'(q.t_near);
        t_max = longint'(q.t_far);
        res   = '0;
        if (c > 0 && b > 0)
            return res;
        bb   = (b * b) >>> Q_FRAC;
        disc = bb - c;
        if (disc < 0)
            return res;
        t = longint'(root_floor(longint'(disc) << Q_FRAC)) - b;
        res.root_valid = 1'b1;
        res.hit        = (t_min <= t) && (t <= t_max);   // unsaturated t
        if (t > T_HI)
            res.t_value = COORD_W'(T_HI);
        else if (t < T_LO)
            res.t_value = COORD_W'(T_LO);
        else
            res.t_value = COORD_W'(t);
        return res;
    endfunction

    function automatic int rand_signed(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // mostly rays aimed at the sphere, some from inside, some random, some pure noise
    function automatic ray_query_t random_query();
        ray_query_t  q;
        ray_result_t guess;
        logic [$bits(ray_query_t)-1:0] raw;
        int  kind, radius, limit_mode, tv;
        int  ctr [3];
        int  off [3];
        real v [3];
        real len, gain;
        kind   = $urandom_range(0, 99);
        radius = $urandom_range(1, 1 << 18);
        for (int k = 0; k < 3; k++) begin
            ctr[k] = rand_signed(1 << 20);
            off[k] = (kind >= 55 && kind < 70) ? rand_signed(radius / 2)
                                               : rand_signed(1 << 21);
            if (kind < 55)
                v[k] = real'(rand_signed(2 * radius) - off[k]);
            else
                v[k] = real'(rand_signed(1 << 12));
        end
        len = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        if (len < 1.0) begin
            v[0] = 1.0;
            len  = 1.0;
        end
        gain = ($urandom_range(0, 7) == 0) ? 0.5 + real'($urandom_range(0, 149)) / 100.0
                                           : 1.0;
        q.origin_x = COORD_W'(ctr[0] + off[0]);
        q.origin_y = COORD_W'(ctr[1] + off[1]);
        q.origin_z = COORD_W'(ctr[2] + off[2]);
        q.dir_x    = DIR_W'(int'(v[0] / len * 16384.0 * gain));
        q.dir_y    = DIR_W'(int'(v[1] / len * 16384.0 * gain));
        q.dir_z    = DIR_W'(int'(v[2] / len * 16384.0 * gain));
        q.center_x = COORD_W'(ctr[0]);
        q.center_y = COORD_W'(ctr[1]);
        q.center_z = COORD_W'(ctr[2]);
        q.radius   = RAD_W'(radius);
        if (kind >= 85) begin
            for (int k = 0; k < $bits(raw); k++)
                raw[k] = 1'($urandom_range(0, 1));
            q = raw;
        end
        q.t_near = '0;
        q.t_far  = '0;
        guess = far_root_hit(q);
        tv    = int'($signed(guess.t_value));
        limit_mode = $urandom_range(0, 9);
        if (limit_mode < 5) begin
            q.t_near = COORD_W'(rand_signed(1 << 14));
            q.t_far  = COORD_W'($urandom_range(1 << 16, (1 << 23) - 1));
        end else if (limit_mode < 8) begin
            // hug the root so either limit compare may land on equality or one-off
            q.t_near = $urandom_range(0, 1) ? COORD_W'(tv + rand_signed(1)) : CMIN;
            q.t_far  = $urandom_range(0, 1) ? COORD_W'(tv + rand_signed(1)) : CMAX;
        end else if (limit_mode == 8) begin
            q.t_far  = COORD_W'($urandom_range(0, 1 << 20));
            q.t_near = COORD_W'(int'(q.t_far) + int'($urandom_range(1, 1 << 20)));
        end else begin
            q.t_near = COORD_W'($urandom());
            q.t_far  = COORD_W'($urandom());
        end
        return q;
    endfunction

    // idle stretches alternate with back-to-back bursts
    function automatic int sender_gap(int n);
        return (n % 128 < 32) ? 0 : int'($urandom_range(0, 10));
    endfunction

    task automatic issue_query(ray_query_t q, ray_result_t want, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        ray_in <= q;
        start  <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        pending_hits.push_back(want);
    endtask

    always @(posedge i_clk) begin : check_results
        ray_result_t want;
        if (i_rst_n && o_valid) begin
            if (pending_hits.size() == 0) begin
                $error("result word with nothing expected: hit=%0d root_valid=%0d t=%0d",
                       o_hit, o_root_valid, $signed(o_t_value));
                miscompares++;
            end else begin
                want = pending_hits.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    miscompares++;
                end
                if (o_root_valid !== want.root_valid) begin
                    $error("root_valid: expected %0d, got %0d", want.root_valid, o_root_valid);
                    miscompares++;
                end
                if (o_t_value !== want.t_value) begin
                    $error("t_value: expected %0d, got %0d",
                           $signed(want.t_value), $signed(o_t_value));
                    miscompares++;
                end
            end
        end
    end

    initial begin : stimulus
        ray_query_t  q;
        ray_result_t want;
        int          drain;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_PROBES; i++) begin
            q    = PROBES[i].query;
            want = PROBES[i].typed ? PROBES[i].want : far_root_hit(q);
            issue_query(q, want, int'($urandom_range(0, 10)));
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            q = random_query();
            issue_query(q, far_root_hit(q), sender_gap(n));
        end
        @(negedge i_clk);
        start <= 1'b0;

        // allow generous slack for the pipeline to drain before declaring words lost
        drain = 0;
        while (pending_hits.size() != 0 && drain < 1000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_hits.size() != 0) begin
            $error("%0d expected result words never arrived", pending_hits.size());
            miscompares++;
        end
        if (miscompares == 0)
            $display("ray_sphere_intersect_unit: match");
        else
            $display("ray_sphere_intersect_unit: mismatch");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("ray_sphere_intersect_unit: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/rsi_pkg.sv
sv/rsi_sqrt.sv
sv/ray_sphere_intersect_unit.sv
dv/ray_sphere_intersect_unit_test.sv
